/* design/qwsm_pkg.sv */
// Shared constants, register indexes, item mode codes and the command/status
// structs that join the wheel speed meter controller and datapath.
// No dependencies.
`default_nettype none

package qwsm_pkg;

  // Item mode codes
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_EDGE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TICK      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RST_LEFT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RST_RIGHT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RST_BOTH  = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_REVERSE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_REVERSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_DIAMETER = 3'd4;

  // Field and datapath widths
  localparam int PERIOD_W = 8;
  localparam int CPR_W    = 32;
  localparam int DIAM_W   = 10;
  localparam int OUT_W    = 32;
  localparam int DEN_W    = CPR_W + PERIOD_W;
  localparam int NUM_W    = 64;
  localparam int QUO_W    = 32;
  localparam int CIRC_W   = 22;
  localparam int CIRCK_W  = 32;

  // Register reset values
  localparam logic [PERIOD_W-1:0] RESET_PERIOD = 8'd10;
  localparam logic [CPR_W-1:0]    RESET_CPR    = 32'd1000000;
  localparam logic [DIAM_W-1:0]   RESET_DIAM   = 10'd65;

  // Circumference: diameter * pi * 1e6 / 1000, the divide done by reciprocal
  localparam logic [31:0] PI_X1E6     = 32'd3141593;
  localparam logic [63:0] RECIP_1000  = 64'd2199023256;  // ceil(2^41 / 1000)
  localparam int          RECIP_SHIFT = 41;
  localparam logic [31:0] SCALE_1000  = 32'd1000;

  localparam logic [OUT_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SPEED_MIN = 32'h8000_0000;

  typedef struct packed {
    logic accept;       // apply the accepted item to the wheel state
    logic circ_mul;     // diameter * pi, denominator product
    logic circ_recip;   // divide by 1000
    logic circ_scale;   // times 1000
    logic wheel_mul;    // magnitude * scaled circumference
    logic num_add;      // add the rounding half
    logic div_start;    // saturation check and divider launch
    logic finish;       // write the wheel speed
    logic wheel_sel;    // 0 left, 1 right
    logic load_out;     // capture the result word
  } qwsm_cmd_t;

  typedef struct packed {
    logic update_hit;   // tick item that closes a speed period
    logic div_busy;
  } qwsm_stat_t;

endpackage

`default_nettype wire

/* design/qwsm_if.sv */
// Channel interfaces of the wheel speed meter: input item, result word and
// configuration write. Depends on qwsm_pkg.
`default_nettype none

interface qwsm_item_if import qwsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic              left_edge;
  logic              right_edge;
  logic              left_b_level;
  logic              right_b_level;

  modport source (output valid, mode, left_edge, right_edge, left_b_level,
                  right_b_level, input ready);
  modport sink   (input valid, mode, left_edge, right_edge, left_b_level,
                  right_b_level, output ready);
endinterface

interface qwsm_result_if import qwsm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] left_count_out;
  logic signed [OUT_W-1:0] right_count_out;
  logic signed [OUT_W-1:0] left_speed_out;
  logic signed [OUT_W-1:0] right_speed_out;
  logic                    speed_updated;

  modport source (output valid, left_count_out, right_count_out, left_speed_out,
                  right_speed_out, speed_updated, input ready);
  modport sink   (input valid, left_count_out, right_count_out, left_speed_out,
                  right_speed_out, speed_updated, output ready);
endinterface

interface qwsm_cfg_if import qwsm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/quadrature_wheel_speed_meter.sv */
// Top level of the two-wheel quadrature counter and speed meter.
// Depends on qwsm_pkg, qwsm_if, qwsm_ctrl, qwsm_dp, qwsm_div.
//
// One result word comes out for every item taken in. Edge, reset, unused-mode
// and ordinary tick items go from acceptance straight to the emit state. A tick
// that closes a speed period first works out the circumference and divisor in
// S_CIRC1 to S_CIRC3, then each wheel in turn goes through multiply and add,
// the shared serial divider (one quotient bit per cycle) and a step to write
// the speed. A new item is taken once the controller is back to idle, even
// while the previous word still waits in the output register. Configuration
// writes are always ready and must only come while no item is in flight.
`default_nettype none

module quadrature_wheel_speed_meter import qwsm_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  qwsm_cfg_if.sink       cfg,
  qwsm_item_if.sink      items,
  qwsm_result_if.source  results
);

  qwsm_cmd_t  cmd;
  qwsm_stat_t stat;

  assign cfg.ready = 1'b1;

  qwsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qwsm_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .mode            (items.mode),
    .left_edge       (items.left_edge),
    .right_edge      (items.right_edge),
    .left_b_level    (items.left_b_level),
    .right_b_level   (items.right_b_level),
    .cmd             (cmd),
    .stat            (stat),
    .left_count_out  (results.left_count_out),
    .right_count_out (results.right_count_out),
    .left_speed_out  (results.left_speed_out),
    .right_speed_out (results.right_speed_out),
    .speed_updated   (results.speed_updated)
  );

endmodule

`default_nettype wire

/* design/qwsm_div.sv */
// Serial restoring divider: one quotient bit per cycle while busy.
// The upper numerator half must be below the divisor. Depends on qwsm_pkg.
`default_nettype none

module qwsm_div import qwsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [QUO_W-1:0]     num_hi,
  input  logic [QUO_W-1:0]     num_lo,
  input  logic [DEN_W-1:0]     den,
  output logic                 busy,
  output logic [QUO_W-1:0]     quot
);

  localparam int CNT_W = $clog2(QUO_W);

  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   den_ext;
  logic             fits;

  assign shifted = {rem, quo[QUO_W-1]};
  assign den_ext = {1'b0, den};
  assign fits    = shifted >= den_ext;
  assign quot    = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(QUO_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DEN_W'(num_hi);
      quo <= num_lo;
    end else if (busy) begin
      rem <= fits ? DEN_W'(shifted - den_ext) : shifted[DEN_W-1:0];
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

/* design/qwsm_dp.sv */
// Datapath of the wheel speed meter: configuration registers, wheel counts,
// prescaler, speed arithmetic and the result register. Depends on qwsm_pkg, qwsm_div.
`default_nettype none

module qwsm_dp import qwsm_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [MODE_W-1:0]       mode,
  input  logic                    left_edge,
  input  logic                    right_edge,
  input  logic                    left_b_level,
  input  logic                    right_b_level,
  input  qwsm_cmd_t               cmd,
  output qwsm_stat_t              stat,
  output logic signed [OUT_W-1:0] left_count_out,
  output logic signed [OUT_W-1:0] right_count_out,
  output logic signed [OUT_W-1:0] left_speed_out,
  output logic signed [OUT_W-1:0] right_speed_out,
  output logic                    speed_updated
);

  // Configuration
  logic                left_reverse;
  logic                right_reverse;
  logic [PERIOD_W-1:0] period;
  logic [CPR_W-1:0]    cpr;
  logic [DIAM_W-1:0]   diam;

  // Wheel state
  logic [COUNT_WIDTH-1:0] left_count;
  logic [COUNT_WIDTH-1:0] right_count;
  logic [COUNT_WIDTH-1:0] left_prev;
  logic [COUNT_WIDTH-1:0] right_prev;
  logic [OUT_W-1:0]       left_speed;
  logic [OUT_W-1:0]       right_speed;
  logic [PERIOD_W-1:0]    presc;
  logic                   updated;

  // Speed arithmetic
  logic [COUNT_WIDTH-1:0] left_delta;
  logic [COUNT_WIDTH-1:0] right_delta;
  logic [DEN_W-1:0]       den;
  logic [31:0]            diam_pi;
  logic [CIRC_W-1:0]      circ;
  logic [CIRCK_W-1:0]     circk;
  logic [NUM_W-1:0]       mprod;
  logic [NUM_W-1:0]       num;
  logic                   neg;
  logic                   zero;
  logic                   sat;

  logic [PERIOD_W-1:0]    presc_inc;
  logic [COUNT_WIDTH-1:0] left_step;
  logic [COUNT_WIDTH-1:0] right_step;
  logic [COUNT_WIDTH-1:0] delta_sel;
  logic [COUNT_WIDTH-1:0] mag;
  logic [63:0]            recip_prod;
  logic [QUO_W-1:0]       quot;
  logic                   div_busy;
  logic [OUT_W-1:0]       speed_res;

  assign presc_inc       = presc + 1'b1;
  assign stat.update_hit = (mode == MODE_TICK) && (presc_inc >= period);
  assign stat.div_busy   = div_busy;

  // B high counts up; the reverse flag flips the direction
  assign left_step  = (left_b_level ^ left_reverse) ? left_count + 1'b1 : left_count - 1'b1;
  assign right_step = (right_b_level ^ right_reverse) ? right_count + 1'b1
                                                      : right_count - 1'b1;

  assign delta_sel  = cmd.wheel_sel ? right_delta : left_delta;
  assign mag        = delta_sel[COUNT_WIDTH-1] ? COUNT_WIDTH'(0) - delta_sel : delta_sel;
  assign recip_prod = 64'(diam_pi) * RECIP_1000;

  always_comb begin
    if (zero) begin
      speed_res = '0;
    end else if (sat) begin
      speed_res = neg ? SPEED_MIN : SPEED_MAX;
    end else if (neg) begin
      speed_res = quot[QUO_W-1] ? SPEED_MIN : OUT_W'(0) - OUT_W'(quot);
    end else begin
      speed_res = quot[QUO_W-1] ? SPEED_MAX : OUT_W'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_reverse  <= 1'b0;
      right_reverse <= 1'b0;
      period        <= RESET_PERIOD;
      cpr           <= RESET_CPR;
      diam          <= RESET_DIAM;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEFT_REVERSE:   left_reverse  <= cfg_data[0];
        REG_RIGHT_REVERSE:  right_reverse <= cfg_data[0];
        REG_SPEED_PERIOD:   period        <= cfg_data[PERIOD_W-1:0];
        REG_COUNTS_PER_REV: cpr           <= cfg_data[CPR_W-1:0];
        REG_WHEEL_DIAMETER: diam          <= cfg_data[DIAM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
      left_prev   <= '0;
      right_prev  <= '0;
      left_speed  <= '0;
      right_speed <= '0;
      presc       <= '0;
      updated     <= 1'b0;
    end else if (cmd.accept) begin
      updated <= stat.update_hit;
      case (mode)
        MODE_EDGE: begin
          if (left_edge) begin
            left_count <= left_step;
          end
          if (right_edge) begin
            right_count <= right_step;
          end
        end
        MODE_TICK: begin
          if (stat.update_hit) begin
            presc      <= '0;
            left_prev  <= left_count;
            right_prev <= right_count;
          end else begin
            presc <= presc_inc;
          end
        end
        MODE_RST_LEFT: begin
          left_count <= '0;
          left_prev  <= '0;
          left_speed <= '0;
        end
        MODE_RST_RIGHT: begin
          right_count <= '0;
          right_prev  <= '0;
          right_speed <= '0;
        end
        MODE_RST_BOTH: begin
          left_count  <= '0;
          left_prev   <= '0;
          left_speed  <= '0;
          right_count <= '0;
          right_prev  <= '0;
          right_speed <= '0;
          presc       <= '0;
        end
        default: ;
      endcase
    end else if (cmd.finish) begin
      if (cmd.wheel_sel) begin
        right_speed <= speed_res;
      end else begin
        left_speed <= speed_res;
      end
    end
  end

  // Arithmetic pipeline registers, stepped by the controller
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      left_delta  <= left_count - left_prev;
      right_delta <= right_count - right_prev;
    end
    if (cmd.circ_mul) begin
      diam_pi <= 32'(diam) * PI_X1E6;
      den     <= DEN_W'(cpr) * DEN_W'(period);
    end
    if (cmd.circ_recip) begin
      circ <= recip_prod[RECIP_SHIFT +: CIRC_W];
    end
    if (cmd.circ_scale) begin
      circk <= CIRCK_W'(circ) * SCALE_1000;
    end
    if (cmd.wheel_mul) begin
      neg   <= delta_sel[COUNT_WIDTH-1];
      zero  <= delta_sel == '0;
      mprod <= NUM_W'(mag) * NUM_W'(circk);
    end
    if (cmd.num_add) begin
      num <= mprod + NUM_W'(den >> 1);
    end
    if (cmd.div_start) begin
      // Quotient needs more than 32 bits, or the divisor is zero
      sat <= DEN_W'(num[NUM_W-1:QUO_W]) >= den;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      left_count_out  <= OUT_W'(signed'(left_count));
      right_count_out <= OUT_W'(signed'(right_count));
      left_speed_out  <= left_speed;
      right_speed_out <= right_speed;
      speed_updated   <= updated;
    end
  end

  qwsm_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .num_hi (num[NUM_W-1:QUO_W]),
    .num_lo (num[QUO_W-1:0]),
    .den    (den),
    .busy   (div_busy),
    .quot   (quot)
  );

endmodule

`default_nettype wire

/* design/qwsm_ctrl.sv */
// Controller of the wheel speed meter: input handshake, speed update
// sequence and result word handshake. Depends on qwsm_pkg.
`default_nettype none

module qwsm_ctrl import qwsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  qwsm_stat_t stat,
  output qwsm_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CIRC1 = 4'd1;
  localparam logic [3:0] S_CIRC2 = 4'd2;
  localparam logic [3:0] S_CIRC3 = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_LOAD  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       wheel;
  logic       wheel_next;
  logic       out_valid_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next     = state;
    wheel_next     = wheel;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.wheel_sel  = wheel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          wheel_next = 1'b0;
          state_next = stat.update_hit ? S_CIRC1 : S_EMIT;
        end
      end
      S_CIRC1: begin
        cmd.circ_mul = 1'b1;
        state_next   = S_CIRC2;
      end
      S_CIRC2: begin
        cmd.circ_recip = 1'b1;
        state_next     = S_CIRC3;
      end
      S_CIRC3: begin
        cmd.circ_scale = 1'b1;
        state_next     = S_MUL;
      end
      S_MUL: begin
        cmd.wheel_mul = 1'b1;
        state_next    = S_ADD;
      end
      S_ADD: begin
        cmd.num_add = 1'b1;
        state_next  = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (wheel) begin
          state_next = S_EMIT;
        end else begin
          wheel_next = 1'b1;
          state_next = S_MUL;
        end
      end
      S_EMIT: begin
        // Hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wheel     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wheel     <= wheel_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

/* design/qwsm_checker.sv */
// Port-level checks of the wheel speed meter, bound to the top level.
// Depends on qwsm_pkg for the result width.
`default_nettype none

module qwsm_port_checker import qwsm_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] left_count_out,
  input logic                    speed_updated
);

  logic [1:0] outstanding;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items taken in whose word has not yet left
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding <= outstanding + 1'b1;
    end else if (out_acc && !in_acc) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_count_out) &&
                                $stable(speed_updated))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("item taken while the previous one is at work");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> outstanding != 2'd0)
    else $error("result word without a pending item");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more than two items pending");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quadrature_wheel_speed_meter qwsm_port_checker u_qwsm_port_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (items.valid),
  .in_ready       (items.ready),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .left_count_out (results.left_count_out),
  .speed_updated  (results.speed_updated)
);

`default_nettype wire

/* test/qwsm_checker.sv */
// Checker for the wheel speed meter: follows register writes and accepted item
// words, predicts each result word and compares it with what the block sends.
// Depends on qwsm_pkg and qwsm_if.
`timescale 1ns / 100ps

module qwsm_checker import qwsm_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic   clk,
  input  logic   rst,
  qwsm_cfg_if    cfg,
  qwsm_item_if   items,
  qwsm_result_if results,
  output int     words_pending,
  output int     mismatches
);

  localparam logic [31:0] CNT_MASK = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  typedef struct packed {
    logic [OUT_W-1:0] left_count;
    logic [OUT_W-1:0] right_count;
    logic [OUT_W-1:0] left_speed;
    logic [OUT_W-1:0] right_speed;
    logic             speed_updated;
  } speed_word_t;

  // Register copies
  logic                left_rev;
  logic                right_rev;
  logic [PERIOD_W-1:0] period_ms;
  logic [CPR_W-1:0]    cpr_x1000;
  logic [DIAM_W-1:0]   diam_mm;

  // Wheel state
  logic [31:0]         left_cnt;
  logic [31:0]         right_cnt;
  logic [31:0]         left_base;
  logic [31:0]         right_base;
  logic [31:0]         left_mmps;
  logic [31:0]         right_mmps;
  logic [PERIOD_W-1:0] ms_prescale;

  speed_word_t expected_words[$];
  int          fault_count = 0;

  function automatic logic [31:0] cnt_sext(input logic [31:0] v);
    logic [31:0] r;
    r = v & CNT_MASK;
    if (r[COUNT_WIDTH-1]) r = r | ~CNT_MASK;
    return r;
  endfunction

  function automatic logic [31:0] cnt_step(input logic [31:0] cnt, input logic up);
    return (up ? cnt + 32'd1 : cnt - 32'd1) & CNT_MASK;
  endfunction

  // Count change over one period to mm/s, rounded half away from zero
  function automatic logic [31:0] mm_per_s(input logic [31:0] delta);
    logic [31:0] d;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] circ;
    logic [63:0] den;
    logic [63:0] q;
    d    = cnt_sext(delta);
    neg  = d[31];
    mag  = {32'd0, neg ? 32'd0 - d : d};
    circ = (64'(diam_mm) * 64'(PI_X1E6)) / 64'(SCALE_1000);
    den  = 64'(cpr_x1000) * 64'(period_ms);
    if (mag == 64'd0) return 32'd0;
    if (den == 64'd0) return neg ? SPEED_MIN : SPEED_MAX;
    q = (mag * circ * 64'(SCALE_1000) + den / 64'd2) / den;
    if (neg) return (q >= 64'h8000_0000) ? SPEED_MIN : 32'd0 - q[31:0];
    return (q > 64'h7FFF_FFFF) ? SPEED_MAX : q[31:0];
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin
    speed_word_t want;
    logic        updated;
    if (rst) begin
      left_rev    = 1'b0;
      right_rev   = 1'b0;
      period_ms   = RESET_PERIOD;
      cpr_x1000   = RESET_CPR;
      diam_mm     = RESET_DIAM;
      left_cnt    = '0;
      right_cnt   = '0;
      left_base   = '0;
      right_base  = '0;
      left_mmps   = '0;
      right_mmps  = '0;
      ms_prescale = '0;
      expected_words.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LEFT_REVERSE:   left_rev  = cfg.data[0];
          REG_RIGHT_REVERSE:  right_rev = cfg.data[0];
          REG_SPEED_PERIOD:   period_ms = cfg.data[PERIOD_W-1:0];
          REG_COUNTS_PER_REV: cpr_x1000 = cfg.data[CPR_W-1:0];
          REG_WHEEL_DIAMETER: diam_mm   = cfg.data[DIAM_W-1:0];
          default: ;
        endcase
      end

      // Retire the result word before queueing a new prediction
      if (results.valid && results.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no item waiting for it");
          fault_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("left_count_out", want.left_count, results.left_count_out);
          check_field("right_count_out", want.right_count, results.right_count_out);
          check_field("left_speed_out", want.left_speed, results.left_speed_out);
          check_field("right_speed_out", want.right_speed, results.right_speed_out);
          check_field("speed_updated", {31'd0, want.speed_updated},
                      {31'd0, results.speed_updated});
        end
      end

      if (items.valid && items.ready) begin
        updated = 1'b0;
        case (items.mode)
          MODE_EDGE: begin
            if (items.left_edge)
              left_cnt = cnt_step(left_cnt, items.left_b_level ^ left_rev);
            if (items.right_edge)
              right_cnt = cnt_step(right_cnt, items.right_b_level ^ right_rev);
          end
          MODE_TICK: begin
            ms_prescale = ms_prescale + 1'b1;
            if (ms_prescale >= period_ms) begin
              ms_prescale = '0;
              left_mmps   = mm_per_s((left_cnt - left_base) & CNT_MASK);
              right_mmps  = mm_per_s((right_cnt - right_base) & CNT_MASK);
              left_base   = left_cnt;
              right_base  = right_cnt;
              updated     = 1'b1;
            end
          end
          MODE_RST_LEFT: begin
            left_cnt  = '0;
            left_base = '0;
            left_mmps = '0;
          end
          MODE_RST_RIGHT: begin
            right_cnt  = '0;
            right_base = '0;
            right_mmps = '0;
          end
          MODE_RST_BOTH: begin
            left_cnt    = '0;
            left_base   = '0;
            left_mmps   = '0;
            right_cnt   = '0;
            right_base  = '0;
            right_mmps  = '0;
            ms_prescale = '0;
          end
          default: ;
        endcase
        expected_words.push_back('{cnt_sext(left_cnt), cnt_sext(right_cnt),
                                   left_mmps, right_mmps, updated});
      end
    end
    words_pending <= expected_words.size();
    mismatches    <= fault_count;
  end

endmodule

/* test/tb_quadrature_wheel_speed_meter.sv */
// Testbench top for the wheel speed meter: drives clock, reset, register
// writes and item words under varying back pressure; qwsm_checker judges.
// Depends on qwsm_pkg, qwsm_if, qwsm_checker and the block itself.
`timescale 1ns / 100ps

module tb_quadrature_wheel_speed_meter;
  import qwsm_pkg::*;

  localparam int COUNT_WIDTH   = 32;
  localparam int NUM_PHASES    = 8;
  localparam int CYCLE_LIMIT   = 1_200_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 100;
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   words_pending;
  int   mismatches;

  // Per-phase knobs
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   tick_pct;
  int   clear_pct;
  int   up_bias;
  int   phase_words;

  qwsm_cfg_if    cfg ();
  qwsm_item_if   items ();
  qwsm_result_if results ();

  quadrature_wheel_speed_meter #(.COUNT_WIDTH(COUNT_WIDTH)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .items   (items),
    .results (results)
  );

  qwsm_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .items         (items),
    .results       (results),
    .words_pending (words_pending),
    .mismatches    (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    results.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("quadrature_wheel_speed_meter verification failed");
      $finish;
    end
  end

  // Leave valid high after acceptance; the next call drops it only for a gap
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic le, input logic re,
                           input logic lb, input logic rb);
    while ($urandom_range(99) < send_idle_pct) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid         <= 1'b1;
    items.mode          <= mode;
    items.left_edge     <= le;
    items.right_edge    <= re;
    items.left_b_level  <= lb;
    items.right_b_level <= rb;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
  endtask

  task automatic send_random_word();
    int                pick;
    logic [MODE_W-1:0] mode;
    pick = $urandom_range(99);
    if (pick < tick_pct)
      mode = MODE_TICK;
    else if (pick < tick_pct + clear_pct)
      mode = MODE_W'($urandom_range(MODE_RST_BOTH, MODE_RST_LEFT));
    else if (pick < tick_pct + clear_pct + 4)
      mode = MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
    else
      mode = MODE_EDGE;
    send_word(mode, 1'($urandom_range(1)), 1'($urandom_range(1)),
              $urandom_range(99) < up_bias, $urandom_range(99) < up_bias);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic lrev, input logic rrev, input logic [7:0] period,
                              input logic [31:0] cpr, input logic [9:0] diam);
    write_reg(REG_LEFT_REVERSE, {31'd0, lrev});
    write_reg(REG_RIGHT_REVERSE, {31'd0, rrev});
    write_reg(REG_SPEED_PERIOD, {24'd0, period});
    write_reg(REG_COUNTS_PER_REV, cpr);
    write_reg(REG_WHEEL_DIAMETER, {22'd0, diam});
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and hold until every predicted word has come back
  task automatic settle();
    items.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic setup_phase(input int phase);
    tick_pct    = 30;
    clear_pct   = 6;
    phase_words = 170;
    case (phase)
      1: begin
        send_idle_pct = 0;  recv_stall_pct = 0;  up_bias = 50; phase_words = 180;
        program_regs(1'b1, 1'b0, 8'd1, 32'd1, 10'd1023);
      end
      2: begin
        // long period: mostly ticks, no clears, so the prescaler gets there
        send_idle_pct = 88; recv_stall_pct = 0;  up_bias = 90; phase_words = 400;
        tick_pct = 80; clear_pct = 0;
        program_regs(1'b0, 1'b1, 8'd255, 32'hFFFF_FFFF, 10'd1);
      end
      3: begin
        send_idle_pct = 0;  recv_stall_pct = 88; up_bias = 70; tick_pct = 35;
        program_regs(1'b1, 1'b1, 8'd0, 32'd1000000, 10'd65);
      end
      4: begin
        send_idle_pct = 30; recv_stall_pct = 30; up_bias = 30; tick_pct = 35;
        program_regs(1'b0, 1'b0, 8'd3, 32'd0, 10'd500);
      end
      5: begin
        send_idle_pct = 0;  recv_stall_pct = 0;  up_bias = 50;
        program_regs(1'b1, 1'b0, 8'd2, $urandom(), 10'($urandom_range(1023, 1)));
      end
      6: begin
        send_idle_pct = 88; recv_stall_pct = 0;  up_bias = 80;
        program_regs(1'b0, 1'b1, 8'd5, 32'd4096, 10'd100);
      end
      7: begin
        send_idle_pct = 0;  recv_stall_pct = 88; up_bias = 20;
        program_regs(1'b0, 1'b0, 8'd1, $urandom_range(5000, 1),
                     10'($urandom_range(1023, 1)));
      end
      default: begin
        send_idle_pct = 30; recv_stall_pct = 30; up_bias = 60;
        program_regs(1'b1, 1'b1, 8'd4, 32'd2000, 10'd1023);
      end
    endcase
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg.valid           <= 1'b0;
    cfg.index           <= REG_LEFT_REVERSE;
    cfg.data            <= '0;
    items.valid         <= 1'b0;
    items.mode          <= MODE_EDGE;
    items.left_edge     <= 1'b0;
    items.right_edge    <= 1'b0;
    items.left_b_level  <= 1'b0;
    items.right_b_level <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under reset register values, no gaps
    send_word(MODE_EDGE, 1'b1, 1'b0, 1'b1, 1'b0);
    send_word(MODE_EDGE, 1'b1, 1'b0, 1'b0, 1'b0);
    send_word(MODE_EDGE, 1'b0, 1'b1, 1'b0, 1'b1);
    send_word(MODE_EDGE, 1'b0, 1'b1, 1'b0, 1'b0);
    send_word(MODE_EDGE, 1'b1, 1'b1, 1'b1, 1'b0);
    send_word(MODE_EDGE, 1'b1, 1'b1, 1'b0, 1'b1);
    send_word(MODE_EDGE, 1'b0, 1'b0, 1'b1, 1'b1);
    send_word(MODE_EDGE, 1'b1, 1'b0, 1'b0, 1'b0);
    send_word(MODE_EDGE, 1'b0, 1'b1, 1'b0, 1'b0);
    for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
      send_word(MODE_W'(m), 1'b1, 1'b1, 1'b1, 1'b1);
    // Edge fields on ticks must be ignored; the tenth tick closes the period
    for (int i = 0; i < 10; i++)
      send_word(MODE_TICK, 1'b1, 1'b1, i[0], ~i[0]);
    send_word(MODE_RST_LEFT, 1'b1, 1'b1, 1'b1, 1'b1);
    send_word(MODE_RST_RIGHT, 1'b1, 1'b1, 1'b1, 1'b1);
    send_word(MODE_RST_BOTH, 1'b1, 1'b1, 1'b1, 1'b1);

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      settle();
      setup_phase(phase);
      for (int n = 0; n < phase_words; n++)
        send_random_word();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("quadrature_wheel_speed_meter verification clean");
    else
      $display("quadrature_wheel_speed_meter verification failed");
    $finish;
  end

endmodule
